[rtl/psel_pkg.sv]
// ----------------------------------------------------------------------------
// psel_pkg: shared types and constants for the percentile selector
// Field widths, rank constants, request codes and sequencer states.
// ----------------------------------------------------------------------------
package psel_pkg;

	localparam int SAMPLE_W        = 32;     // Q16.16 sample
	localparam int RANK_W          = 14;     // percentile in hundredths of a percent
	localparam int COUNT_OUT_W     = 9;      // reported set size
	localparam int MAX_SAMPLES_DEF = 256;

	localparam int RANK_FULL  = 10000;       // 100.00 percent
	localparam int RANK_RESET = 9000;        // 90.00 percent

	// request codes on req_type
	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_END = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,    // taking samples
		ST_MUL,     // rank * n
		ST_DIV,     // ceil divide by 10000, reciprocal multiply
		ST_IDX,     // k - 1 and clamp
		ST_SCAN,    // one pass over the store for the current bit
		ST_DRAIN,   // last read of the pass lands
		ST_DECIDE,  // fix the current result bit
		ST_DONE     // hand result to output register
	} psel_state_t;

endpackage

[rtl/psel_ram.sv]
// ----------------------------------------------------------------------------
// psel_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module psel_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/percentile_select.sv]
// A sample beat is stored in its accept cycle; the next beat can follow at once.
// End-of-set beat: starts the selection, and the result is loaded once the result
//   register is free, where n is the set size; an empty set skips the search.
// The single RAM read port sets the pace: each of the 32 result bits costs one
//   pass over the n stored samples. in_ready is low for the whole selection.
// Reset (arst_n low): set empty, drop flag clear, rank 90.00 percent, no result pending.
// ----------------------------------------------------------------------------
// percentile_select: nearest-rank percentile over a set of Q16.16 samples
// Samples are written into a RAM; an end-of-set beat computes
// idx = clamp(ceil(rank * n / 10000) - 1) and finds the idx-th smallest
// sample by a bitwise radix select, MSB first, with one shared compare unit.
// ----------------------------------------------------------------------------
module percentile_select #(
	parameter int MAX_SAMPLES = psel_pkg::MAX_SAMPLES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             req_type,
	input  logic [psel_pkg::SAMPLE_W-1:0]    sample_value,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [psel_pkg::SAMPLE_W-1:0]    percentile_result,
	output logic [psel_pkg::COUNT_OUT_W-1:0] sample_count,
	output logic                             overflowed,
	// configuration: percentile_rank
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [psel_pkg::RANK_W-1:0]      cfg_data
);

	import psel_pkg::*;

	localparam int AW     = $clog2(MAX_SAMPLES);      // store address
	localparam int CW     = $clog2(MAX_SAMPLES + 1);  // set size 0..MAX_SAMPLES
	localparam int PW     = RANK_W + CW;              // rank * n + 9999 fits here
	localparam int BW     = $clog2(SAMPLE_W);         // result bit index
	// floor(x / 10000) = (x * RECIP) >> SHIFT, exact for x < 2^PW since 2^RANK_W >= 10000
	localparam int SHIFT  = PW + RANK_W;
	localparam int PRODW  = 2 * PW + 1;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(RANK_FULL - 1)) / 64'(RANK_FULL);

	// ---------------------------------------------------------------- config
	logic [RANK_W-1:0] rank_q;
	logic [RANK_W-1:0] rank_sat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_W'(RANK_RESET);
		end else if (cfg_valid && cfg_ready) begin
			rank_q <= cfg_data;
		end
	end

	// ranks above 100.00 percent behave as 100.00 percent
	assign rank_sat = (rank_q > RANK_W'(RANK_FULL)) ? RANK_W'(RANK_FULL) : rank_q;

	// ------------------------------------------------------------- sequencer
	psel_state_t state_q, state_d;

	logic            in_acc;
	logic            ram_re;
	logic            out_load;
	logic            addr_last;
	logic            out_valid_q;
	logic [CW-1:0]   held_q;
	logic            drop_q;
	logic [BW-1:0]   bit_q;

	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ram_re   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && req_type == REQ_END) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				// empty set answers zero without a search
				state_d = (held_q == '0) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				state_d = ST_IDX;
			end
			ST_IDX: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				ram_re = 1'b1;
				if (addr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = (bit_q == '0) ? ST_DONE : ST_SCAN;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------- sample store
	logic [AW-1:0]       rd_addr_q;
	logic [SAMPLE_W-1:0] rd_data;
	logic                ram_we;
	logic                rd_vld_s1;

	assign ram_we    = in_acc && req_type == REQ_ADD && held_q < CW'(MAX_SAMPLES);
	assign addr_last = (CW'(rd_addr_q) == held_q - CW'(1));

	psel_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (held_q[AW-1:0]),
		.wdata (sample_value),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (rd_data)
	);

	// set size and drop flag; cleared when the result is handed over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			drop_q <= 1'b0;
		end else if (out_load) begin
			held_q <= '0;
			drop_q <= 1'b0;
		end else if (in_acc && req_type == REQ_ADD) begin
			if (ram_we) begin
				held_q <= held_q + CW'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------- rank index: ceil(r*n/10000)
	logic [PW-1:0]    dvd_q;
	logic [CW-1:0]    quo_q;
	logic [PRODW-1:0] prod;
	logic [CW-1:0]    k_m1;

	// quotient by reciprocal multiply; k <= n, so it fits in CW bits
	assign prod = PRODW'(dvd_q) * PRODW'(RECIP);
	assign k_m1 = (quo_q == '0) ? '0 : quo_q - CW'(1);

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			dvd_q <= PW'(rank_sat) * PW'(held_q) + PW'(RANK_FULL - 1);
		end else if (state_q == ST_DIV) begin
			quo_q <= prod[SHIFT +: CW];
		end
	end

	// ------------------------------------------------------ radix selection
	// For bit b (MSB first) count samples that agree with the result prefix
	// above b and have bit b clear. If the index falls among them the bit
	// is 0, otherwise it is 1 and the index moves past them.
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       cnt_q;
	logic [SAMPLE_W-1:0] prefix_q;
	logic [SAMPLE_W-1:0] bit_mask;
	logic                hit;

	assign bit_mask = {SAMPLE_W{1'b1}} << bit_q;
	assign hit      = (((rd_data ^ prefix_q) & bit_mask) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_MUL: begin
				prefix_q <= '0;
			end
			ST_IDX: begin
				// k <= n always, so only the low side needs clamping
				idx_q     <= (k_m1 > held_q - CW'(1)) ? held_q - CW'(1) : k_m1;
				bit_q     <= BW'(SAMPLE_W - 1);
				rd_addr_q <= '0;
				cnt_q     <= '0;
			end
			ST_SCAN, ST_DRAIN: begin
				if (ram_re) begin
					rd_addr_q <= rd_addr_q + AW'(1);
				end
				if (rd_vld_s1 && hit) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			ST_DECIDE: begin
				if (idx_q >= cnt_q) begin
					idx_q           <= idx_q - cnt_q;
					prefix_q[bit_q] <= 1'b1;
				end
				bit_q     <= bit_q - BW'(1);
				rd_addr_q <= '0;
				cnt_q     <= '0;
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------ output register
	logic [SAMPLE_W-1:0]    res_q;
	logic [COUNT_OUT_W-1:0] cnt_out_q;
	logic                   ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q     <= prefix_q;
			cnt_out_q <= COUNT_OUT_W'(held_q);
			ovf_q     <= drop_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign percentile_result = res_q;
	assign sample_count      = cnt_out_q;
	assign overflowed        = ovf_q;

endmodule
